// ===== rtl/core/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg
// Shared types and constants of the cross-kernel sharpening stream: pixel and
// result words, the line store entry, configuration register codes and sizes.
// ----------------------------------------------------------------------------
package csh_pkg;

    // Configuration port.
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Register values after reset, before the limit to the maximum frame size.
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;

    // Default maximum frame size.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Result queue depth; a power of two, at least four.
    localparam int FIFO_DEPTH = 4;

    // One incoming pixel.
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_t;

    // One outgoing result.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } res_t;

    // One line store entry: a column of the two most recent rows.
    typedef struct packed {
        pix_t newer;
        pix_t older;
    } line_t;

endpackage

// ===== rtl/core/csh_ram.sv =====
// ----------------------------------------------------------------------------
// csh_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered; the read data holds until the next read.
// ----------------------------------------------------------------------------
module csh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/csh_kernel.sv =====
// ----------------------------------------------------------------------------
// csh_kernel
// Cross-kernel arithmetic: five times the centre minus the four neighbours,
// per color channel, clamped to 0..255. Border pixels pass the centre.
// ----------------------------------------------------------------------------
module csh_kernel (
    input  csh_pkg::pix_t left,
    input  csh_pkg::pix_t centre,
    input  csh_pkg::pix_t right,
    input  csh_pkg::pix_t up,
    input  csh_pkg::pix_t down,
    input  logic          interior,
    output csh_pkg::pix_t result
);

    import csh_pkg::*;

    // The sum spans -1020..1275, so twelve signed bits hold it.
    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] c,
        input logic [7:0] l,
        input logic [7:0] r,
        input logic [7:0] u,
        input logic [7:0] d
    );
        logic signed [11:0] acc;
        acc = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
            - $signed({4'b0000, l}) - $signed({4'b0000, r})
            - $signed({4'b0000, u}) - $signed({4'b0000, d});
        if (acc[11])
        begin
            return 8'h00;
        end
        else if (acc[10:8] != 3'b000)
        begin
            return 8'hFF;
        end
        else
        begin
            return acc[7:0];
        end
    endfunction

    pix_t sharp;

    always_comb
    begin
        sharp.in_red   = sharpen_chan(centre.in_red, left.in_red, right.in_red,
                                      up.in_red, down.in_red);
        sharp.in_green = sharpen_chan(centre.in_green, left.in_green, right.in_green,
                                      up.in_green, down.in_green);
        sharp.in_blue  = sharpen_chan(centre.in_blue, left.in_blue, right.in_blue,
                                      up.in_blue, down.in_blue);
        result = interior ? sharp : centre;
    end

endmodule

// ===== rtl/core/csh_fifo.sv =====
// ----------------------------------------------------------------------------
// csh_fifo
// Result queue in front of the output port. Takes up to two words per cycle
// in order, gives one word per cycle from its head while pop is high.
// ----------------------------------------------------------------------------
module csh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 push_cnt,
    input  csh_pkg::res_t              push_first,
    input  csh_pkg::res_t              push_second,
    input  logic                       pop,
    output csh_pkg::res_t              head,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    import csh_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        fill_next   = fill_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_first;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= push_second;
        end
    end

    assign head = entry_reg[rd_ptr_reg];
    assign fill = fill_reg;

endmodule

// ===== rtl/core/cross_kernel_sharpen_stream.sv =====
// ----------------------------------------------------------------------------
// cross_kernel_sharpen_stream
// 3x3 cross-kernel sharpening of an RGB raster stream, using one line store
// that keeps the two most recent rows side by side in each entry.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   pix       in         pix_valid / pix_stall  pix_word (pix_t)
//   res       out        res_valid / res_stall  res_word (res_t)
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel is taken per clock cycle while pix_stall is low. The line store
// has one read and one write port, and each pixel uses each of them once,
// which sets that rate. On the last row of a frame each pixel gives two
// words, one in a single-row frame. Reset clears counters and control; the
// line store needs no clearing pass. pix_stall rises when the result queue
// could not hold the next pixel's words.
//
// The line store entry at column x holds {row y-1, row y-2} while row y
// streams in. When pixel x is taken, the entry for the column after next is
// read, so the right neighbor is in the RAM output register when needed and
// the centre and left sit in two window registers. The entry at column x is
// rewritten at the same edge with the current pixel and the old newer row.
// For frames narrower than three pixels the read address can equal the write
// address; a bypass register then supplies the freshly written entry. In a
// single-column frame the next pixel needs the entry written at this very
// edge, so the window takes it straight from the write data.
//
module cross_kernel_sharpen_stream #(
    parameter int MAX_WIDTH  = csh_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csh_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  csh_pkg::pix_t                    pix_word,
    output logic                             res_valid,
    input  logic                             res_stall,
    output csh_pkg::res_t                    res_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [csh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import csh_pkg::*;

    // Column index, frame width, row index and frame height widths.
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int HCMP = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = FW + 1;

    localparam logic [WW-1:0] W_RST = (RST_FRAME_WIDTH > MAX_WIDTH) ?
                                      WW'(MAX_WIDTH) : WW'(RST_FRAME_WIDTH);
    localparam logic [HW-1:0] H_RST = (RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                                      HW'(MAX_HEIGHT) : HW'(RST_FRAME_HEIGHT);

    // Frame size, already limited to 1..maximum.
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [WW-1:0] w_fit;
    logic [HW-1:0] h_fit;

    // Raster position of the next pixel.
    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [YW-1:0] row_reg;
    logic [YW-1:0] row_next;

    // Window around the next pixel and the bypass for narrow frames.
    line_t         mid_reg;
    pix_t          left_reg;
    line_t         byp_reg;
    logic          byp_hit_reg;
    line_t         right_slot;
    line_t         ram_rdata;

    // Compute stage.
    logic          s1_valid_reg;
    logic          s1_res_reg;
    logic          s1_echo_reg;
    logic          s1_interior_reg;
    logic          s1_end_reg;
    pix_t          s1_cur_reg;
    pix_t          s1_left_reg;
    pix_t          s1_centre_reg;
    pix_t          s1_right_reg;
    pix_t          s1_up_reg;
    pix_t          s1_result;
    logic [1:0]    s1_cnt;

    logic          pix_take;
    logic          cfg_take;
    logic          last_col;
    logic          last_row;
    logic [XW-1:0] col_after;
    logic [XW-1:0] rd_col;
    line_t         wr_entry;
    logic [FW-1:0] fifo_fill;
    res_t          push_first;
    res_t          push_second;
    res_t          sharp_word;
    res_t          echo_word;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid & cfg_ready;
    assign pix_take  = pix_valid & ~pix_stall;

    // Limit a written frame size: zero means one, above the maximum saturates.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            w_fit = WW'(1);
            h_fit = HW'(1);
        end
        else
        begin
            w_fit = (WCMP'(cfg_data) > WCMP'(MAX_WIDTH)) ?
                    WW'(MAX_WIDTH) : WW'(cfg_data);
            h_fit = (HCMP'(cfg_data) > HCMP'(MAX_HEIGHT)) ?
                    HW'(MAX_HEIGHT) : HW'(cfg_data);
        end
    end

    // Raster counters and the address of the column after next.
    always_comb
    begin
        last_col  = (WW'(col_reg) + WW'(1)) == w_reg;
        last_row  = (HW'(row_reg) + HW'(1)) == h_reg;
        col_after = last_col ? '0 : col_reg + XW'(1);
        rd_col    = ((WW'(col_after) + WW'(1)) == w_reg) ? '0 : col_after + XW'(1);
        col_next  = col_after;
        if (last_col)
        begin
            row_next = last_row ? '0 : row_reg + YW'(1);
        end
        else
        begin
            row_next = row_reg;
        end
        right_slot     = byp_hit_reg ? byp_reg : ram_rdata;
        wr_entry.newer = pix_word;
        wr_entry.older = mid_reg.newer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= W_RST;
            h_reg        <= H_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            byp_hit_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_take;
            if (cfg_take)
            begin
                // A write to the width or height register restarts the frame.
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        w_reg       <= w_fit;
                        col_reg     <= '0;
                        row_reg     <= '0;
                        byp_hit_reg <= 1'b0;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        h_reg       <= h_fit;
                        col_reg     <= '0;
                        row_reg     <= '0;
                        byp_hit_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (pix_take)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                byp_hit_reg <= (rd_col == col_reg);
            end
        end
    end

    // Window and compute stage payload.
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            mid_reg         <= (w_reg == WW'(1)) ? wr_entry : right_slot;
            left_reg        <= mid_reg.newer;
            byp_reg         <= wr_entry;
            s1_res_reg      <= (row_reg != '0);
            s1_echo_reg     <= last_row;
            s1_interior_reg <= (row_reg >= YW'(2)) && (col_reg != '0) && !last_col;
            s1_end_reg      <= last_col;
            s1_cur_reg      <= pix_word;
            s1_left_reg     <= left_reg;
            s1_centre_reg   <= mid_reg.newer;
            s1_up_reg       <= mid_reg.older;
            s1_right_reg    <= right_slot.newer;
        end
    end

    csh_ram #(
        .WIDTH ($bits(line_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (pix_take),
        .waddr (col_reg),
        .wdata (wr_entry),
        .re    (pix_take),
        .raddr (rd_col),
        .rdata (ram_rdata)
    );

    csh_kernel u_kernel (
        .left     (s1_left_reg),
        .centre   (s1_centre_reg),
        .right    (s1_right_reg),
        .up       (s1_up_reg),
        .down     (s1_cur_reg),
        .interior (s1_interior_reg),
        .result   (s1_result)
    );

    // The result for the row above goes first, then the echo of the last row.
    always_comb
    begin
        sharp_word.out_red   = s1_result.in_red;
        sharp_word.out_green = s1_result.in_green;
        sharp_word.out_blue  = s1_result.in_blue;
        sharp_word.frame_end = 1'b0;
        echo_word.out_red    = s1_cur_reg.in_red;
        echo_word.out_green  = s1_cur_reg.in_green;
        echo_word.out_blue   = s1_cur_reg.in_blue;
        echo_word.frame_end  = s1_end_reg;
        push_first  = s1_res_reg ? sharp_word : echo_word;
        push_second = echo_word;
        if (s1_valid_reg)
        begin
            s1_cnt = 2'(s1_res_reg) + 2'(s1_echo_reg);
        end
        else
        begin
            s1_cnt = 2'd0;
        end
    end

    csh_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (s1_cnt),
        .push_first  (push_first),
        .push_second (push_second),
        .pop         (res_valid & ~res_stall),
        .head        (res_word),
        .fill        (fifo_fill)
    );

    assign res_valid = (fifo_fill != '0);

    // A pixel is taken only if the queue keeps room for two more words after
    // the words of the compute stage are in.
    assign pix_stall = (SW'(fifo_fill) + SW'(s1_cnt)) > SW'(FIFO_DEPTH - 2);

    // The raster position stays inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (WW'(col_reg) < w_reg))
        else $error("column counter outside the frame width");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (HW'(row_reg) < h_reg))
        else $error("row counter outside the frame height");

    // Read and write collide only in frames narrower than three pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
                     byp_hit_reg |-> (w_reg < WW'(3)))
        else $error("line store bypass used in a wide frame");

    // The compute stage never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
                     s1_valid_reg |-> ((SW'(fifo_fill) + SW'(s1_cnt)) <= SW'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

// ===== tb/tb_cross_kernel_sharpen_stream.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cross_kernel_sharpen_stream
// Self-checking bench for the cross-kernel sharpening stream. Pixels are
// streamed in raster order with random gaps, results are taken with random
// stalls, and every result word is compared field by field with a predictor
// that keeps its own copy of the line store, counters and frame geometry.
// ----------------------------------------------------------------------------
module tb_cross_kernel_sharpen_stream;
    import csh_pkg::*;

    localparam int unsigned MAX_W       = DEF_MAX_WIDTH;
    localparam int unsigned MAX_H       = DEF_MAX_HEIGHT;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // The block answers through its registers, and a row-0 pixel of a taller
    // frame answers with nothing, so we wait before any register write.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned RESET_PIXELS  = 40;
    localparam int unsigned RANDOM_PIXELS = 150;
    localparam int unsigned MAX_REPORTS   = 40;

    // Register indexes past the end of the list; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   pix_valid;
    logic                   pix_stall;
    pix_t                   pix_word;
    logic                   res_valid;
    logic                   res_stall;
    res_t                   res_word;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: two row banks of the line store, the raster position
    // and the raw register values as written.
    logic [23:0]           row_history [0:2*MAX_W-1];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    res_t        expected_words[$];
    int unsigned mismatch_count = 0;
    int unsigned words_checked  = 0;
    int unsigned pixels_sent    = 0;
    int unsigned cycle_count    = 0;
    // Odds of an idle burst on either side; zero means no idling for a while.
    int unsigned idle_odds      = 0;
    bit          steady_tail    = 1'b0;

    cross_kernel_sharpen_stream i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A zero size counts as one, and sizes above the maximum saturate.
    function automatic int unsigned fit_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    function automatic logic [7:0] clamp_level(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return 8'(v);
    endfunction

    // Works out the words caused by one accepted pixel: first the finished
    // pixel one row up in the same column, then on the last row an echo of
    // the arriving pixel itself.
    task automatic predict_sharpened(input pix_t px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned now_base;
        int unsigned prev_base;
        logic [23:0] cur;
        logic [23:0] cen;
        logic [23:0] lft;
        logic [23:0] rgt;
        logic [23:0] up;
        logic [23:0] sharp;
        int          v;
        res_t        word;
        begin
            w = fit_dim(width_reg, MAX_W);
            h = fit_dim(height_reg, MAX_H);
            x = col_pos;
            y = row_pos;
            cur = px;
            now_base  = (y % 2) * MAX_W;
            prev_base = ((y + 1) % 2) * MAX_W;
            if (x >= w)
                x = 0;
            if (y >= h)
                y = 0;

            if (y >= 1)
            begin
                cen = row_history[prev_base + x];
                sharp = cen;
                // Interior of the frame: the row above is not the first row,
                // this row is not past the last, and both side columns exist.
                if (y >= 2 && y + 1 <= h && x >= 1 && x + 2 <= w)
                begin
                    lft = row_history[prev_base + x - 1];
                    rgt = row_history[prev_base + x + 1];
                    up  = row_history[now_base + x];
                    for (int s = 0; s <= 16; s += 8)
                    begin
                        v = 5 * int'(cen[s +: 8]) - int'(lft[s +: 8]) - int'(rgt[s +: 8])
                            - int'(up[s +: 8]) - int'(cur[s +: 8]);
                        sharp[s +: 8] = clamp_level(v);
                    end
                end
                word.out_red   = sharp[23:16];
                word.out_green = sharp[15:8];
                word.out_blue  = sharp[7:0];
                word.frame_end = 1'b0;
                expected_words.push_back(word);
            end

            row_history[now_base + x] = cur;

            if (y + 1 == h)
            begin
                word.out_red   = px.in_red;
                word.out_green = px.in_green;
                word.out_blue  = px.in_blue;
                word.frame_end = (x + 1 == w);
                expected_words.push_back(word);
            end

            x++;
            if (x >= w)
            begin
                x = 0;
                y++;
                if (y >= h)
                    y = 0;
            end
            col_pos = x;
            row_pos = y;
        end
    endtask

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Every caller enters at a falling edge and leaves at one. A write only
    // happens once all expected words are out and the pipeline has settled.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        begin
            while (expected_words.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            do
                @(posedge clk);
            while (!cfg_ready);
            // A write to a real register restarts the raster at a new frame.
            if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
            begin
                if (idx == REG_FRAME_WIDTH)
                    width_reg = val;
                else
                    height_reg = val;
                col_pos = 0;
                row_pos = 0;
            end
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        begin
            if ($urandom_range(0, 1))
            begin
                write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
                write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
            end
            else
            begin
                write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
                write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
            end
        end
    endtask

    // Sends one pixel word, with an occasional idle burst ahead of it. The
    // word is held until it is taken, and the prediction is made right then.
    task automatic send_pixel(input pix_t px);
        begin
            if (!steady_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                repeat ($urandom_range(1, 16)) @(negedge clk);
            pix_valid = 1'b1;
            pix_word  = px;
            do
                @(posedge clk);
            while (pix_stall);
            predict_sharpened(px);
            pixels_sent++;
            @(negedge clk);
            pix_valid = 1'b0;
        end
    endtask

    // Channel levels lean toward the rails so the clamps are hit often.
    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_t random_pixel();
        pix_t px;
        px.in_red   = random_level();
        px.in_green = random_level();
        px.in_blue  = random_level();
        return px;
    endfunction

    task automatic stream_pixels(input int unsigned count);
        begin
            repeat (count) send_pixel(random_pixel());
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch: word %0d cycle %0d %s got %0h want %0h",
                         words_checked, cycle_count, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Nothing is written yet, so the reset size of 640 by 480 applies. A
    // stretch of the top row gives no words; a wrong reset height of one
    // would echo them.
    task automatic test_reset_geometry();
        begin
            stream_pixels(RESET_PIXELS);
        end
    endtask

    // One 3x3 frame with a single interior pixel. Red drives the sum far
    // above the top rail, green far below zero, and blue lands in range.
    task automatic test_clamp_extremes();
        pix_t grid [0:8];
        begin
            grid[0] = '{8'd0,   8'd255, 8'd7};
            grid[1] = '{8'd0,   8'd255, 8'd30};
            grid[2] = '{8'd0,   8'd255, 8'd9};
            grid[3] = '{8'd0,   8'd255, 8'd10};
            grid[4] = '{8'd255, 8'd0,   8'd60};
            grid[5] = '{8'd0,   8'd255, 8'd20};
            grid[6] = '{8'd0,   8'd255, 8'd11};
            grid[7] = '{8'd0,   8'd255, 8'd40};
            grid[8] = '{8'd0,   8'd255, 8'd13};
            set_geometry(3, 3);
            for (int i = 0; i < 9; i++)
                send_pixel(grid[i]);
        end
    endtask

    // Frames too small to have an interior, including the zero sizes that
    // count as one, a single row and a single column.
    task automatic test_tiny_frames();
        begin
            set_geometry(2, 2);
            stream_pixels(4);
            set_geometry(0, 0);
            stream_pixels(2);
            set_geometry(4, 1);
            stream_pixels(4);
            set_geometry(1, 4);
            stream_pixels(4);
        end
    endtask

    // Writes to the spare indexes land in the middle of a frame and must
    // neither change the size nor restart the raster.
    task automatic test_spare_index();
        begin
            set_geometry(5, 3);
            stream_pixels(7);
            write_register(REG_SPARE_A, '1);
            stream_pixels(4);
            write_register(REG_SPARE_B, '0);
            stream_pixels(4);
        end
    endtask

    // A real register write in the middle of a frame starts a fresh frame.
    task automatic test_restart_mid_frame();
        begin
            set_geometry(4, 4);
            stream_pixels(6);
            write_register(REG_FRAME_HEIGHT, 11'd3);
            stream_pixels(12);
        end
    endtask

    // An all-ones width saturates to the maximum. One long single row shows
    // the limit through the place of its frame end.
    task automatic test_saturated_size();
        begin
            set_geometry(2047, 1);
            stream_pixels(MAX_W);
        end
    endtask

    // Mostly whole frames of small random size, a few wider ones, some
    // frames cut short and some spare-index writes between pixels.
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned frame_pixels;
        int unsigned cut;
        int unsigned stop_at;
        begin
            stop_at = pixels_sent + RANDOM_PIXELS;
            while (pixels_sent < stop_at)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        w = $urandom_range(3, 12);
                        h = $urandom_range(3, 6);
                    end
                    6:
                    begin
                        w = $urandom_range(1, 2);
                        h = $urandom_range(1, 8);
                    end
                    7:
                    begin
                        w = $urandom_range(1, 12);
                        h = $urandom_range(1, 2);
                    end
                    8:
                    begin
                        w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                        h = (w == 0) ? $urandom_range(0, 5) : 0;
                    end
                    default:
                    begin
                        w = $urandom_range(13, 40);
                        h = $urandom_range(3, 4);
                    end
                endcase
                set_geometry(w, h);
                frame_pixels = fit_dim(CFG_DATA_W'(w), MAX_W) * fit_dim(CFG_DATA_W'(h), MAX_H);
                case ($urandom_range(0, 9))
                    0:
                        // Broken frame: the next geometry write abandons it.
                        stream_pixels($urandom_range(1, frame_pixels));
                    1:
                    begin
                        cut = $urandom_range(1, frame_pixels);
                        stream_pixels(cut);
                        write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                       CFG_DATA_W'($urandom_range(0, 2047)));
                        stream_pixels(frame_pixels - cut);
                    end
                    default:
                        stream_pixels(frame_pixels * $urandom_range(1, 2));
                endcase
            end
        end
    endtask

    // Last part: no idling on either side, two frames back to back.
    task automatic test_back_to_back();
        begin
            steady_tail = 1'b1;
            set_geometry(6, 4);
            stream_pixels(48);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, and the check of every taken word
    // ------------------------------------------------------------------------

    initial
    begin : result_stall_gen
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady_tail || idle_odds == 0 || $urandom_range(1, idle_odds) != 1)
                res_stall = 1'b0;
            else
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
        end
    end

    initial
    begin : result_check
        res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected", 32'(res_word), 32'd0);
                else
                begin
                    want = expected_words.pop_front();
                    if (res_word.out_red !== want.out_red)
                        report_mismatch("out_red", 32'(res_word.out_red),
                                        32'(want.out_red));
                    if (res_word.out_green !== want.out_green)
                        report_mismatch("out_green", 32'(res_word.out_green),
                                        32'(want.out_green));
                    if (res_word.out_blue !== want.out_blue)
                        report_mismatch("out_blue", 32'(res_word.out_blue),
                                        32'(want.out_blue));
                    if (res_word.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(res_word.frame_end),
                                        32'(want.frame_end));
                end
                words_checked++;
            end
        end
    end

    // Cycle counter: it also redraws the idling mood as it counts, so that busy
    // stretches alternate with calm ones, and it ends a run that has hung.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count % 300 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_odds = 0;
                    1: idle_odds = 3;
                    default: idle_odds = 12;
                endcase
            end
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin : run_tests
        rst_n      = 1'b0;
        pix_valid  = 1'b0;
        pix_word   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_data   = '0;
        width_reg  = CFG_DATA_W'(RST_FRAME_WIDTH);
        height_reg = CFG_DATA_W'(RST_FRAME_HEIGHT);
        col_pos    = 0;
        row_pos    = 0;
        for (int i = 0; i < 2 * MAX_W; i++)
            row_history[i] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_geometry();
        test_clamp_extremes();
        test_tiny_frames();
        test_spare_index();
        test_restart_mid_frame();
        test_saturated_size();
        test_random_frames();
        test_back_to_back();

        // Drain what is still on its way, then give the pipeline time to
        // show any word that should not be there.
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/csh_pkg.sv
rtl/core/csh_ram.sv
rtl/core/csh_kernel.sv
rtl/core/csh_fifo.sv
rtl/core/cross_kernel_sharpen_stream.sv
tb/tb_cross_kernel_sharpen_stream.sv
